>>> hdl/odc_pkg.sv
// Shared types and constants of the omni drive command block.
// Used by odc_mac and omniwheel_drive_command; depends on nothing.
`default_nettype none

package odc_pkg;

    localparam int VEL_W      = 24;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 28;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int GOAL_W     = 8;
    localparam int VEL_SHIFT  = 20;
    localparam int RPM_SHIFT  = 28;

    typedef logic [3:0] t_opcode;
    localparam t_opcode OP_START      = 4'd0;
    localparam t_opcode OP_STOP       = 4'd1;
    localparam t_opcode OP_TRANSLATE  = 4'd2;
    localparam t_opcode OP_TRACTOR    = 4'd3;
    localparam t_opcode OP_SPIN_LEFT  = 4'd4;
    localparam t_opcode OP_SPIN_RIGHT = 4'd5;
    localparam t_opcode OP_HEAD_UP    = 4'd6;
    localparam t_opcode OP_HEAD_DOWN  = 4'd7;
    localparam t_opcode OP_KNOB_PRESS = 4'd8;
    localparam t_opcode OP_KNOB_TURN  = 4'd9;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_DISABLED  = 2'd0;
    localparam t_mode MODE_UNLIMITED = 2'd1;
    localparam t_mode MODE_LIMITED   = 2'd2;

    localparam logic [1:0] UNIT_COUNT = 2'd3;

    localparam logic [0:0] CFG_RPM_LIMIT     = 1'b0;
    localparam logic [0:0] CFG_LIMITED_SCALE = 1'b1;

    localparam logic [6:0] RPM_LIMIT_RST     = 7'd100;
    localparam logic [8:0] LIMITED_SCALE_RST = 9'd128;
    localparam logic [9:0] FACTOR_UNITY      = 10'd256;

    // gains in Q24
    localparam logic signed [MUL_B_W-1:0] GAIN_TRANS   = 28'sd67628957;
    localparam logic signed [MUL_B_W-1:0] GAIN_TRACTOR = 28'sd452985;
    localparam logic signed [MUL_B_W-1:0] GAIN_BUTTON  = 28'sd177641;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } t_mac_ctl;

    // wheel matrix, Q16, RPM prescale folded in
    function automatic logic signed [MUL_B_W-1:0] wheel_coef(
        input logic [1:0] row,
        input logic [1:0] col
    );
        logic signed [MUL_B_W-1:0] c;
        case ({row, col})
            4'b00_00: c = -28'sd6884;
            4'b00_01: c = -28'sd14707;
            4'b00_10: c = 28'sd1706806;
            4'b01_00: c = -28'sd6884;
            4'b01_01: c = 28'sd14707;
            4'b01_10: c = 28'sd1706806;
            4'b10_00: c = 28'sd16271;
            4'b10_01: c = 28'sd0;
            4'b10_10: c = 28'sd2356973;
            default:  c = 28'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/odc_mac.sv
// Shared multiply-accumulate unit with velocity and RPM rounding.
// Depends on odc_pkg.
`default_nettype none

module odc_mac (
    input  wire logic                                  i_clk,
    input  wire odc_pkg::t_mac_ctl                     i_ctl,
    input  wire logic signed [odc_pkg::MUL_A_W-1:0]    i_a,
    input  wire logic signed [odc_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [odc_pkg::PROD_W-1:0]          o_prod,
    output logic signed [odc_pkg::VEL_W-1:0]           o_vel,
    output logic signed [odc_pkg::GOAL_W-1:0]          o_rpm
);

    localparam int PW   = odc_pkg::PROD_W;
    localparam int VS   = odc_pkg::VEL_SHIFT;
    localparam int RS   = odc_pkg::RPM_SHIFT;
    localparam int VW   = odc_pkg::VEL_W;
    localparam int GW   = odc_pkg::GOAL_W;
    localparam int VSHW = PW - VS;
    localparam int RSHW = PW - RS;

    localparam logic signed [PW-1:0] VEL_HALF = {{(PW-VS){1'b0}}, 1'b1, {(VS-1){1'b0}}};
    localparam logic signed [PW-1:0] RPM_HALF = {{(PW-RS){1'b0}}, 1'b1, {(RS-1){1'b0}}};

    localparam logic signed [VSHW-1:0] VEL_MAX = {{(VSHW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [VSHW-1:0] VEL_MIN = {{(VSHW-VW+1){1'b1}}, {(VW-1){1'b0}}};
    localparam logic signed [RSHW-1:0] RPM_MAX = {{(RSHW-GW+1){1'b0}}, {(GW-1){1'b1}}};
    localparam logic signed [RSHW-1:0] RPM_MIN = {{(RSHW-GW+1){1'b1}}, {(GW-1){1'b0}}};

    logic signed [PW-1:0]   r_prod;
    logic signed [PW-1:0]   r_acc;
    logic signed [PW-1:0]   mul_full;
    logic signed [PW-1:0]   vel_biased;
    logic signed [PW-1:0]   rpm_biased;
    logic signed [VSHW-1:0] vel_sh;
    logic signed [RSHW-1:0] rpm_sh;

    assign mul_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= mul_full;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // half away from zero: negative values get half minus one before the shift
    assign vel_biased = r_prod + (r_prod[PW-1] ? (VEL_HALF - 1'b1) : VEL_HALF);
    assign rpm_biased = r_acc + (r_acc[PW-1] ? (RPM_HALF - 1'b1) : RPM_HALF);
    assign vel_sh     = vel_biased[PW-1:VS];
    assign rpm_sh     = rpm_biased[PW-1:RS];

    always_comb begin
        if (vel_sh > VEL_MAX) begin
            o_vel = VEL_MAX[VW-1:0];
        end else if (vel_sh < VEL_MIN) begin
            o_vel = VEL_MIN[VW-1:0];
        end else begin
            o_vel = vel_sh[VW-1:0];
        end
        if (rpm_sh > RPM_MAX) begin
            o_rpm = RPM_MAX[GW-1:0];
        end else if (rpm_sh < RPM_MIN) begin
            o_rpm = RPM_MIN[GW-1:0];
        end else begin
            o_rpm = rpm_sh[GW-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> hdl/omniwheel_drive_command.sv
// Top level: gamepad event decode, drive mode, body velocity and wheel goals.
// Depends on odc_pkg and odc_mac.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+-----------------------------------------
//  event in | i_valid / o_ready          | opcode, x_value, y_value, unit_index
//  result   | o_valid / i_ready          | goals, flags, head power, knob, mode
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word at a time; o_ready is high only while idle. Events without motion go from
// S_EXEC straight to S_FIN; motion events first use the single 24x28 multiplier: each
// matrix product is registered in S_MX_MUL and accumulated in S_MX_ACC, nine matrix
// products per motion event plus two or four scaling products.
// Reset is synchronous and active low; a finished word waits in the output register
// and the next event is taken meanwhile. Config is always ready.
`default_nettype none

module omniwheel_drive_command (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [3:0]        i_opcode,
    input  wire logic signed [8:0] i_x_value,
    input  wire logic signed [7:0] i_y_value,
    input  wire logic [1:0]        i_unit_index,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [7:0]      o_left_goal,
    output logic signed [7:0]      o_right_goal,
    output logic signed [7:0]      o_rear_goal,
    output logic                   o_goals_written,
    output logic                   o_set_rejected,
    output logic signed [7:0]      o_head_power,
    output logic                   o_head_written,
    output logic                   o_knob_write,
    output logic                   o_knob_all,
    output logic [1:0]             o_knob_number,
    output logic signed [7:0]      o_knob_position,
    output logic [1:0]             o_control_mode,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [8:0]        i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_EXEC     = 10'b0000000010,
        S_SC_MUL1  = 10'b0000000100,
        S_SC_MUL2  = 10'b0000001000,
        S_SC_STORE = 10'b0000010000,
        S_MX_MUL   = 10'b0000100000,
        S_MX_ACC   = 10'b0001000000,
        S_MX_ROW   = 10'b0010000000,
        S_CHECK    = 10'b0100000000,
        S_FIN      = 10'b1000000000
    } t_state;

    localparam int MA_W = odc_pkg::MUL_A_W;
    localparam int MB_W = odc_pkg::MUL_B_W;
    localparam int VW   = odc_pkg::VEL_W;

    t_state r_state, n_state;

    odc_pkg::t_opcode        r_op;
    logic signed [8:0]       r_x;
    logic signed [7:0]       r_y;
    logic [1:0]              r_unit;
    odc_pkg::t_mode          r_mode;
    logic [6:0]              r_rpm_limit;
    logic [8:0]              r_limited_scale;
    logic signed [VW-1:0]    r_vel_x, r_vel_y, r_vel_spin;
    logic signed [7:0]       r_goal [3];
    logic signed [7:0]       r_rpm [3];
    logic                    r_job;
    logic [1:0]              r_row, r_col;

    logic                    r_written, r_rejected, r_head_wr, r_kwrite, r_kall;
    logic signed [7:0]       r_head;
    logic [1:0]              r_knum;
    logic signed [7:0]       r_kpos;

    logic                    r_out_valid;
    logic signed [7:0]       r_out_left, r_out_right, r_out_rear;
    logic                    r_out_written, r_out_rejected, r_out_head_wr;
    logic signed [7:0]       r_out_head;
    logic                    r_out_kwrite, r_out_kall;
    logic [1:0]              r_out_knum;
    logic signed [7:0]       r_out_kpos;
    logic [1:0]              r_out_mode;

    odc_pkg::t_mac_ctl       mac_ctl;
    logic signed [MA_W-1:0]  mac_a;
    logic signed [MB_W-1:0]  mac_b;
    logic signed [odc_pkg::PROD_W-1:0] mac_prod;
    logic signed [VW-1:0]    mac_vel;
    logic signed [7:0]       mac_rpm;

    logic                    in_accept, out_load, is_motion, two_jobs, unit_ok;
    logic signed [9:0]       x_ext, x_neg, sc_in;
    logic signed [MB_W-1:0]  sc_gain;
    logic [9:0]              factor;
    logic signed [VW-1:0]    vel_sel;
    logic [8:0]              x_mag;
    logic [14:0]             mag100;
    logic [23:0]             mag_recip;
    logic [7:0]              q0;
    logic [15:0]             q0_255, rem;
    logic [7:0]              head_q;
    logic                    head_neg;
    logic signed [7:0]       head_val;
    logic [7:0]              abs0, abs1, abs2;
    logic                    over_limit;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_valid && o_ready;
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || i_ready);
    assign unit_ok     = (r_unit < odc_pkg::UNIT_COUNT);

    assign is_motion = (r_mode != odc_pkg::MODE_DISABLED) &&
                       (r_op == odc_pkg::OP_TRANSLATE || r_op == odc_pkg::OP_TRACTOR ||
                        r_op == odc_pkg::OP_SPIN_LEFT || r_op == odc_pkg::OP_SPIN_RIGHT);
    assign two_jobs  = (r_op == odc_pkg::OP_TRANSLATE) || (r_op == odc_pkg::OP_TRACTOR);

    // scaling operands: first job is x (or -x), second job is y
    assign x_ext = {r_x[8], r_x};
    assign x_neg = -x_ext;

    always_comb begin
        if (r_job) begin
            sc_in   = {{2{r_y[7]}}, r_y};
            sc_gain = odc_pkg::GAIN_TRANS;
        end else begin
            sc_in = (r_op == odc_pkg::OP_TRACTOR || r_op == odc_pkg::OP_SPIN_RIGHT) ?
                    x_neg : x_ext;
            case (r_op)
                odc_pkg::OP_TRANSLATE: sc_gain = odc_pkg::GAIN_TRANS;
                odc_pkg::OP_TRACTOR:   sc_gain = odc_pkg::GAIN_TRACTOR;
                default:               sc_gain = odc_pkg::GAIN_BUTTON;
            endcase
        end
        case (r_mode)
            odc_pkg::MODE_UNLIMITED: factor = odc_pkg::FACTOR_UNITY;
            odc_pkg::MODE_LIMITED:   factor = {1'b0, r_limited_scale};
            default:                 factor = '0;
        endcase
        case (r_col)
            2'd0:    vel_sel = r_vel_x;
            2'd1:    vel_sel = r_vel_y;
            2'd2:    vel_sel = r_vel_spin;
            default: vel_sel = '0;
        endcase
    end

    // shared unit operand steering
    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (r_state)
            S_EXEC: begin
                mac_ctl.acc_clr = 1'b1;
            end
            S_SC_MUL1: begin
                mac_ctl.mul_en = 1'b1;
                mac_a = MA_W'(sc_in);
                mac_b = MB_W'(factor);
            end
            S_SC_MUL2: begin
                mac_ctl.mul_en = 1'b1;
                mac_a = mac_prod[MA_W-1:0];
                mac_b = sc_gain;
            end
            S_MX_MUL: begin
                mac_ctl.mul_en = 1'b1;
                mac_a = vel_sel;
                mac_b = odc_pkg::wheel_coef(r_row, r_col);
            end
            S_MX_ACC: begin
                mac_ctl.acc_add = 1'b1;
            end
            S_MX_ROW: begin
                mac_ctl.acc_clr = 1'b1;
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    odc_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (mac_prod),
        .o_vel  (mac_vel),
        .o_rpm  (mac_rpm)
    );

    // head power: |x|*100/255 via 257/65536 estimate plus one correction step
    assign x_mag     = r_x[8] ? 9'(-r_x) : 9'(r_x);
    assign mag100    = 15'(x_mag) * 15'd100;
    assign mag_recip = {mag100, 8'd0} + 24'(mag100);
    assign q0        = mag_recip[23:16];
    assign q0_255    = {q0, 8'd0} - 16'(q0);
    assign rem       = 16'(mag100) - q0_255;
    assign head_q    = (rem >= 16'd255) ? q0 + 8'd1 : q0;
    assign head_neg  = r_x[8] ^ (r_op == odc_pkg::OP_HEAD_DOWN);
    assign head_val  = head_neg ? -$signed(head_q) : $signed(head_q);

    assign abs0 = r_rpm[0][7] ? 8'(-r_rpm[0]) : 8'(r_rpm[0]);
    assign abs1 = r_rpm[1][7] ? 8'(-r_rpm[1]) : 8'(r_rpm[1]);
    assign abs2 = r_rpm[2][7] ? 8'(-r_rpm[2]) : 8'(r_rpm[2]);
    assign over_limit = (abs0 > {1'b0, r_rpm_limit}) || (abs1 > {1'b0, r_rpm_limit}) ||
                        (abs2 > {1'b0, r_rpm_limit});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     n_state = in_accept ? S_EXEC : S_IDLE;
            S_EXEC:     n_state = is_motion ? S_SC_MUL1 : S_FIN;
            S_SC_MUL1:  n_state = S_SC_MUL2;
            S_SC_MUL2:  n_state = S_SC_STORE;
            S_SC_STORE: n_state = (!r_job && two_jobs) ? S_SC_MUL1 : S_MX_MUL;
            S_MX_MUL:   n_state = S_MX_ACC;
            S_MX_ACC:   n_state = (r_col == 2'd2) ? S_MX_ROW : S_MX_MUL;
            S_MX_ROW:   n_state = (r_row == 2'd2) ? S_CHECK : S_MX_MUL;
            S_CHECK:    n_state = S_FIN;
            S_FIN:      n_state = out_load ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_mode          <= odc_pkg::MODE_LIMITED;
            r_rpm_limit     <= odc_pkg::RPM_LIMIT_RST;
            r_limited_scale <= odc_pkg::LIMITED_SCALE_RST;
            r_vel_x         <= '0;
            r_vel_y         <= '0;
            r_vel_spin      <= '0;
            r_goal[0]       <= '0;
            r_goal[1]       <= '0;
            r_goal[2]       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    odc_pkg::CFG_RPM_LIMIT:     r_rpm_limit     <= i_cfg_data[6:0];
                    odc_pkg::CFG_LIMITED_SCALE: r_limited_scale <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_EXEC: begin
                    if (r_op == odc_pkg::OP_START) begin
                        if (r_x != '0) begin
                            case (r_mode)
                                odc_pkg::MODE_DISABLED:  r_mode <= odc_pkg::MODE_UNLIMITED;
                                odc_pkg::MODE_UNLIMITED: r_mode <= odc_pkg::MODE_LIMITED;
                                default:                 r_mode <= odc_pkg::MODE_DISABLED;
                            endcase
                        end
                    end else if (r_mode != odc_pkg::MODE_DISABLED) begin
                        case (r_op)
                            odc_pkg::OP_STOP: begin
                                r_goal[0] <= '0;
                                r_goal[1] <= '0;
                                r_goal[2] <= '0;
                            end
                            odc_pkg::OP_KNOB_PRESS: begin
                                if (r_x != '0 && unit_ok) begin
                                    r_goal[r_unit] <= '0;
                                end
                            end
                            odc_pkg::OP_KNOB_TURN: begin
                                if (unit_ok) begin
                                    r_goal[r_unit] <= r_x[7:0];
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SC_STORE: begin
                    if (r_job) begin
                        r_vel_y <= mac_vel;
                    end else if (r_op == odc_pkg::OP_TRANSLATE) begin
                        r_vel_x <= mac_vel;
                    end else begin
                        r_vel_spin <= mac_vel;
                    end
                end
                S_CHECK: begin
                    if (!over_limit) begin
                        r_goal[0] <= -r_rpm[0];
                        r_goal[1] <= r_rpm[1];
                        r_goal[2] <= r_rpm[2];
                    end
                end
                default: ;
            endcase
        end
    end

    // per-event payload: latched input, counters, flags, result word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_opcode;
            r_x    <= i_x_value;
            r_y    <= i_y_value;
            r_unit <= i_unit_index;
        end

        case (r_state)
            S_EXEC: begin
                r_job      <= 1'b0;
                r_written  <= 1'b0;
                r_rejected <= 1'b0;
                r_head_wr  <= 1'b0;
                r_head     <= '0;
                r_kwrite   <= 1'b0;
                r_kall     <= 1'b0;
                r_knum     <= '0;
                r_kpos     <= '0;
                if (r_op == odc_pkg::OP_START) begin
                    r_job <= 1'b0;
                end else if (r_mode != odc_pkg::MODE_DISABLED) begin
                    case (r_op)
                        odc_pkg::OP_STOP: begin
                            r_written <= 1'b1;
                            r_kall    <= 1'b1;
                        end
                        odc_pkg::OP_HEAD_UP, odc_pkg::OP_HEAD_DOWN: begin
                            r_head    <= head_val;
                            r_head_wr <= 1'b1;
                        end
                        odc_pkg::OP_KNOB_PRESS: begin
                            if (r_x != '0 && unit_ok) begin
                                r_written <= 1'b1;
                                r_kwrite  <= 1'b1;
                                r_knum    <= r_unit;
                            end
                        end
                        odc_pkg::OP_KNOB_TURN: begin
                            r_written <= unit_ok;
                        end
                        default: ;
                    endcase
                end else if (r_op == odc_pkg::OP_KNOB_TURN) begin
                    // disabled: echo the stored goal back to the knob
                    r_kwrite <= 1'b1;
                    r_knum   <= r_unit;
                    r_kpos   <= unit_ok ? r_goal[r_unit] : 8'sd0;
                end
            end
            S_SC_STORE: begin
                r_job <= 1'b1;
                r_row <= '0;
                r_col <= '0;
            end
            S_MX_ACC: begin
                if (r_col != 2'd2) begin
                    r_col <= r_col + 2'd1;
                end
            end
            S_MX_ROW: begin
                r_rpm[r_row] <= mac_rpm;
                r_col        <= '0;
                r_row        <= r_row + 2'd1;
            end
            S_CHECK: begin
                r_written  <= !over_limit;
                r_rejected <= over_limit;
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_left     <= r_goal[0];
            r_out_right    <= r_goal[1];
            r_out_rear     <= r_goal[2];
            r_out_written  <= r_written;
            r_out_rejected <= r_rejected;
            r_out_head     <= r_head;
            r_out_head_wr  <= r_head_wr;
            r_out_kwrite   <= r_kwrite;
            r_out_kall     <= r_kall;
            r_out_knum     <= r_knum;
            r_out_kpos     <= r_kpos;
            r_out_mode     <= r_mode;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_goal     = r_out_left;
    assign o_right_goal    = r_out_right;
    assign o_rear_goal     = r_out_rear;
    assign o_goals_written = r_out_written;
    assign o_set_rejected  = r_out_rejected;
    assign o_head_power    = r_out_head;
    assign o_head_written  = r_out_head_wr;
    assign o_knob_write    = r_out_kwrite;
    assign o_knob_all      = r_out_kall;
    assign o_knob_number   = r_out_knum;
    assign o_knob_position = r_out_kpos;
    assign o_control_mode  = r_out_mode;

    a_write_xor_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_goals_written && o_set_rejected))
        else $error("goals written and set rejected in one word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("event taken while a previous one is in work");

    a_stop_clears_goals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_knob_all) |->
            (o_left_goal == 8'sd0 && o_right_goal == 8'sd0 && o_rear_goal == 8'sd0))
        else $error("stop word with nonzero goals");

    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_control_mode == odc_pkg::MODE_DISABLED) |->
            (!o_goals_written && !o_head_written && !o_set_rejected))
        else $error("drive or head output while disabled");

endmodule

`default_nettype wire
